/* hw/rtl/hbk_pkg.sv */
// hbk_pkg: types, constants and the usage translation table for the
// boot keyboard event converter; no dependencies
package hbk_pkg;

  localparam int KEY_SLOTS  = 6;
  localparam int IN_SLOTS   = 6;
  localparam int MOD_EDGES  = 6;
  localparam int NUM_EVENTS = MOD_EDGES + 2 * KEY_SLOTS;
  localparam int IN_W       = 7 + 8 + 8 * IN_SLOTS;
  localparam int IN_BYTES_W = ((IN_W + 7) / 8) * 8;

  localparam logic [6:0] MIN_LENGTH  = 7'd8;
  localparam logic [7:0] NO_CODE     = 8'hff;
  localparam logic [7:0] PAUSE_USAGE = 8'h48;
  localparam logic [7:0] LAST_SKIP   = 8'h01;

  localparam logic KIND_KEY  = 1'b0;
  localparam logic KIND_MENU = 1'b1;

  localparam logic [7:0] MOD_BIT [MOD_EDGES] = '{8'h02, 8'h20, 8'h01, 8'h10, 8'h04, 8'h40};
  localparam logic [6:0] MOD_CODE [MOD_EDGES] = '{7'h70, 7'h70, 7'h74, 7'h74, 7'h73, 7'h73};

  localparam logic [6:0] LETTER_CODES [26] = '{
    7'h1d, 7'h2d, 7'h2b, 7'h1f, 7'h12, 7'h20, 7'h21, 7'h22, 7'h17, 7'h23, 7'h24, 7'h25, 7'h2f,
    7'h2e, 7'h18, 7'h19, 7'h10, 7'h13, 7'h1e, 7'h14, 7'h16, 7'h2c, 7'h11, 7'h2a, 7'h15, 7'h29
  };

  typedef logic [KEY_SLOTS-1:0][7:0] key_arr_t;

  typedef struct packed {
    logic       kind;
    logic [6:0] code;
    logic       pressed;
  } event_t;

  typedef struct packed {
    logic [NUM_EVENTS-1:0]         valid;
    event_t [NUM_EVENTS-1:0]       ev;
  } ev_list_t;

  typedef struct packed {
    logic       rel_valid;
    logic [6:0] rel_code;
    logic       prs_valid;
    logic       prs_kind;
    logic [6:0] prs_code;
  } lane_res_t;

  function automatic logic [7:0] translate(input logic [7:0] u);
    logic [7:0] r;
    logic [7:0] off;
    begin
      r   = NO_CODE;
      off = u - 8'h04;
      if (u >= 8'h04 && u <= 8'h1d) begin
        r = {1'b0, LETTER_CODES[off[4:0]]};
      end else if (u >= 8'h1e && u <= 8'h26) begin
        r = u - 8'h1d;
      end else if (u >= 8'h3a && u <= 8'h43) begin
        r = u + 8'h28;
      end else begin
        case (u)
          8'h27: r = 8'h0a;
          8'h28: r = 8'h1c;
          8'h29: r = 8'h00;
          8'h2a: r = 8'h0e;
          8'h2b: r = 8'h0f;
          8'h2c: r = 8'h34;
          8'h2d: r = 8'h0b;
          8'h2e: r = 8'h0c;
          8'h2f: r = 8'h1a;
          8'h30: r = 8'h1b;
          8'h31: r = 8'h0d;
          8'h32: r = 8'h28;
          8'h33: r = 8'h26;
          8'h34: r = 8'h27;
          8'h36: r = 8'h30;
          8'h37: r = 8'h31;
          8'h38: r = 8'h32;
          8'h39: r = 8'h71;
          8'h46: r = 8'h61;
          8'h47: r = 8'h60;
          8'h49: r = 8'h38;
          8'h4a: r = 8'h3e;
          8'h4b: r = 8'h36;
          8'h4c: r = 8'h39;
          8'h4d: r = 8'h3f;
          8'h4e: r = 8'h37;
          8'h4f: r = 8'h3c;
          8'h50: r = 8'h3b;
          8'h51: r = 8'h3d;
          8'h52: r = 8'h3a;
          8'h54: r = 8'h41;
          8'h55: r = 8'h45;
          8'h56: r = 8'h40;
          8'h57: r = 8'h49;
          8'h58: r = 8'h1c;
          8'h59: r = 8'h4a;
          8'h5a: r = 8'h4b;
          8'h5b: r = 8'h4c;
          8'h5c: r = 8'h46;
          8'h5d: r = 8'h47;
          8'h5e: r = 8'h48;
          8'h5f: r = 8'h42;
          8'h60: r = 8'h43;
          8'h61: r = 8'h44;
          8'h62: r = 8'h4e;
          8'h63: r = 8'h50;
          8'h87: r = 8'h33;
          8'h88: r = 8'h72;
          8'h89: r = 8'h0d;
          8'h8a: r = 8'h35;
          8'h8b: r = 8'h51;
          default: r = NO_CODE;
        endcase
      end
      return r;
    end
  endfunction

endpackage

/* hw/rtl/hbk_lane.sv */
// hbk_lane: per-slot release and press detection with usage translation
// depends on hbk_pkg
module hbk_lane
  import hbk_pkg::*;
(
  input  logic [7:0] prev_key,
  input  logic [7:0] cur_key,
  input  key_arr_t   prev_keys,
  input  key_arr_t   cur_keys,
  output lane_res_t  res
);

  logic       still;
  logic       had;
  logic [7:0] rel_tr;
  logic [7:0] prs_tr;

  always_comb begin
    still = 1'b0;
    had   = 1'b0;
    for (int j = 0; j < KEY_SLOTS; j++) begin
      if (cur_keys[j] == prev_key) still = 1'b1;
      if (prev_keys[j] == cur_key) had = 1'b1;
    end
  end

  assign rel_tr = translate(prev_key);
  assign prs_tr = translate(cur_key);

  always_comb begin
    res.rel_valid = (prev_key > LAST_SKIP) && !still && (rel_tr != NO_CODE);
    res.rel_code  = rel_tr[6:0];
    res.prs_kind  = KIND_KEY;
    res.prs_code  = prs_tr[6:0];
    res.prs_valid = 1'b0;
    if (cur_key > LAST_SKIP && !had) begin
      if (cur_key == PAUSE_USAGE) begin
        res.prs_valid = 1'b1;
        res.prs_kind  = KIND_MENU;
        res.prs_code  = 7'd0;
      end else begin
        res.prs_valid = (prs_tr != NO_CODE);
      end
    end
  end

endmodule

/* hw/rtl/hbk_merge.sv */
// hbk_merge: combines modifier edges and lane results into the ordered event list
// depends on hbk_pkg
module hbk_merge
  import hbk_pkg::*;
(
  input  logic [6:0]             report_length,
  input  logic [7:0]             modifier_bits,
  input  logic [7:0]             prev_modifiers,
  input  lane_res_t [KEY_SLOTS-1:0] lanes,
  output ev_list_t               list
);

  logic now_b;
  logic was_b;
  logic full;

  assign full = (report_length >= MIN_LENGTH);

  always_comb begin
    list = '0;
    now_b = 1'b0;
    was_b = 1'b0;
    for (int m = 0; m < MOD_EDGES; m++) begin
      now_b = |(modifier_bits & MOD_BIT[m]);
      was_b = |(prev_modifiers & MOD_BIT[m]);
      list.valid[m]      = full && (now_b != was_b);
      list.ev[m].kind    = KIND_KEY;
      list.ev[m].code    = MOD_CODE[m];
      list.ev[m].pressed = now_b;
    end
    for (int i = 0; i < KEY_SLOTS; i++) begin
      list.valid[MOD_EDGES + i]      = full && lanes[i].rel_valid;
      list.ev[MOD_EDGES + i].kind    = KIND_KEY;
      list.ev[MOD_EDGES + i].code    = lanes[i].rel_code;
      list.ev[MOD_EDGES + i].pressed = 1'b0;
      list.valid[MOD_EDGES + KEY_SLOTS + i]      = full && lanes[i].prs_valid;
      list.ev[MOD_EDGES + KEY_SLOTS + i].kind    = lanes[i].prs_kind;
      list.ev[MOD_EDGES + KEY_SLOTS + i].code    = lanes[i].prs_code;
      list.ev[MOD_EDGES + KEY_SLOTS + i].pressed = 1'b1;
    end
  end

endmodule

/* hw/rtl/hbk_serializer.sv */
// hbk_serializer: event bank and output register, one event per cycle in list order while out_ready is not held low
// depends on hbk_pkg
module hbk_serializer
  import hbk_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  ev_list_t list,
  output logic     out_valid,
  input  logic     out_ready,
  output event_t   out_ev,
  output logic     out_last
);

  logic [NUM_EVENTS-1:0] mask;
  logic [NUM_EVENTS-1:0] lowbit;
  logic [NUM_EVENTS-1:0] rest;
  logic [NUM_EVENTS-1:0] mask_next;
  event_t [NUM_EVENTS-1:0] bank;
  event_t                ev_sel;
  logic                  load;

  assign lowbit    = mask & (~mask + 1'b1);
  assign rest      = mask & ~lowbit;
  assign load      = (|mask) && (!out_valid || out_ready);
  assign mask_next = load ? rest : mask;
  assign in_ready  = (mask_next == '0);

  always_comb begin
    ev_sel = '0;
    for (int i = 0; i < NUM_EVENTS; i++) begin
      if (lowbit[i]) ev_sel = bank[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask      <= '0;
      out_valid <= 1'b0;
    end else begin
      mask <= (in_valid && in_ready) ? list.valid : mask_next;
      if (load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) bank <= list.ev;
    if (load) begin
      out_ev   <= ev_sel;
      out_last <= (rest == '0);
    end
  end

endmodule

/* hw/rtl/hid_boot_keyboard_event_diff_top.sv */
// the first event of a report passes through the event bank and then the output register
// one event per cycle while m_axis_tready is not held low; a report yields at most 18 events
// a new report is taken in the cycle the previous report's last event moves to the output
// the event bank drains in order: modifier edges, releases, presses, one slot lane each
// reset (synchronous, rst high) clears the stored modifiers and keys and empties the bank
// depends on hbk_pkg, hbk_lane, hbk_merge, hbk_serializer
module hid_boot_keyboard_event_diff_top
  import hbk_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // report_length[6:0], modifier_bits[14:7], key_slot_0..key_slot_5 from bit 15 up, zero pad
  input  logic [IN_BYTES_W-1:0] s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // scan_code[6:0], pressed[7]
  output logic [7:0]            m_axis_tdata,
  // event_kind[0]
  output logic                  m_axis_tuser,
  output logic                  m_axis_tlast
);

  logic [6:0] report_length;
  logic [7:0] modifier_bits;
  key_arr_t   cur_keys;
  logic [7:0] prev_modifiers;
  key_arr_t   prev_keys;
  lane_res_t [KEY_SLOTS-1:0] lanes;
  ev_list_t   list;
  event_t     out_ev;
  logic       accept;

  assign report_length = s_axis_tdata[6:0];
  assign modifier_bits = s_axis_tdata[14:7];

  for (genvar i = 0; i < KEY_SLOTS; i++) begin : g_lane
    if (i < IN_SLOTS) begin : g_in
      assign cur_keys[i] = s_axis_tdata[15 + 8 * i +: 8];
    end else begin : g_zero
      assign cur_keys[i] = 8'd0;
    end
    hbk_lane u_lane (
      .prev_key  (prev_keys[i]),
      .cur_key   (cur_keys[i]),
      .prev_keys (prev_keys),
      .cur_keys  (cur_keys),
      .res       (lanes[i])
    );
  end

  hbk_merge u_merge (
    .report_length  (report_length),
    .modifier_bits  (modifier_bits),
    .prev_modifiers (prev_modifiers),
    .lanes          (lanes),
    .list           (list)
  );

  assign accept = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_modifiers <= '0;
      prev_keys      <= '0;
    end else if (accept && report_length >= MIN_LENGTH) begin
      prev_modifiers <= modifier_bits;
      prev_keys      <= cur_keys;
    end
  end

  hbk_serializer u_ser (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .list      (list),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_ev    (out_ev),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tdata = {out_ev.pressed, out_ev.code};
  assign m_axis_tuser = out_ev.kind;

endmodule

/* sim/tb.sv */
// tb: self-checking bench for hid_boot_keyboard_event_diff_top, feeds boot keyboard
// reports and scores key events against an in-bench model of the report diff
// depends on hbk_pkg and the top-level rtl
module tb
  import hbk_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] NO_SCAN   = 8'hff;
  localparam logic [7:0] PAUSE_KEY = 8'h48;
  localparam logic [7:0] ROLLOVER  = 8'h01;
  localparam int         RANDOM_REPORTS = 200;
  localparam int         CALM_TAIL      = 30;

  localparam logic [7:0] EDGE_MASK [6] = '{8'h02, 8'h20, 8'h01, 8'h10, 8'h04, 8'h40};
  localparam logic [6:0] EDGE_SCAN [6] = '{7'h70, 7'h70, 7'h74, 7'h74, 7'h73, 7'h73};
  localparam logic [6:0] ALPHA_SCAN [26] = '{
    7'h1d, 7'h2d, 7'h2b, 7'h1f, 7'h12, 7'h20, 7'h21, 7'h22, 7'h17, 7'h23, 7'h24, 7'h25, 7'h2f,
    7'h2e, 7'h18, 7'h19, 7'h10, 7'h13, 7'h1e, 7'h14, 7'h16, 7'h2c, 7'h11, 7'h2a, 7'h15, 7'h29
  };

  typedef struct packed {
    logic [6:0] len;
    logic [7:0] mods;
    key_arr_t   slots;
    logic       wait_idle;
  } report_t;

  typedef struct packed {
    logic       kind;
    logic [6:0] code;
    logic       pressed;
    logic       last;
  } key_event_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // report_length[6:0], modifier_bits[14:7], key_slot_0..key_slot_5 from bit 15 up, zero pad
  logic [IN_BYTES_W-1:0] s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // scan_code[6:0], pressed[7]
  logic [7:0]            m_axis_tdata;
  // event_kind[0]
  logic                  m_axis_tuser;
  logic                  m_axis_tlast;

  report_t    pending_reports[$];
  key_event_t expected_events[$];
  report_t    offered;
  logic [7:0] held_mods;
  key_arr_t   held_keys;
  logic [7:0] gen_mods;
  key_arr_t   gen_keys;
  int         events_predicted = 0;
  int         events_seen = 0;
  int         reports_taken = 0;
  int         mismatches = 0;
  int         send_gap = 0;
  int         recv_gap = 0;
  int         hold_left = 0;
  bit         hold_done = 1'b0;
  logic       holding = 1'b0;
  logic       calm = 1'b0;

  hid_boot_keyboard_event_diff_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [7:0] usage_scan(input logic [7:0] u);
    if (u >= 8'h04 && u <= 8'h1d) return {1'b0, ALPHA_SCAN[u - 8'h04]};
    if (u >= 8'h1e && u <= 8'h26) return u - 8'h1d;
    if (u >= 8'h3a && u <= 8'h43) return 8'h62 + (u - 8'h3a);
    case (u)
      8'h27: return 8'h0a;  8'h28: return 8'h1c;  8'h29: return 8'h00;
      8'h2a: return 8'h0e;  8'h2b: return 8'h0f;  8'h2c: return 8'h34;
      8'h2d: return 8'h0b;  8'h2e: return 8'h0c;  8'h2f: return 8'h1a;
      8'h30: return 8'h1b;  8'h31: return 8'h0d;  8'h32: return 8'h28;
      8'h33: return 8'h26;  8'h34: return 8'h27;  8'h36: return 8'h30;
      8'h37: return 8'h31;  8'h38: return 8'h32;  8'h39: return 8'h71;
      8'h46: return 8'h61;  8'h47: return 8'h60;  8'h49: return 8'h38;
      8'h4a: return 8'h3e;  8'h4b: return 8'h36;  8'h4c: return 8'h39;
      8'h4d: return 8'h3f;  8'h4e: return 8'h37;  8'h4f: return 8'h3c;
      8'h50: return 8'h3b;  8'h51: return 8'h3d;  8'h52: return 8'h3a;
      8'h54: return 8'h41;  8'h55: return 8'h45;  8'h56: return 8'h40;
      8'h57: return 8'h49;  8'h58: return 8'h1c;  8'h59: return 8'h4a;
      8'h5a: return 8'h4b;  8'h5b: return 8'h4c;  8'h5c: return 8'h46;
      8'h5d: return 8'h47;  8'h5e: return 8'h48;  8'h5f: return 8'h42;
      8'h60: return 8'h43;  8'h61: return 8'h44;  8'h62: return 8'h4e;
      8'h63: return 8'h50;  8'h87: return 8'h33;  8'h88: return 8'h72;
      8'h89: return 8'h0d;  8'h8a: return 8'h35;  8'h8b: return 8'h51;
      default: return NO_SCAN;
    endcase
  endfunction

  task automatic predict_report(input report_t r);
    int         first;
    bit         now_on;
    bit         was_on;
    bit         found;
    logic [7:0] scan;
    logic [7:0] k;
    first = expected_events.size();
    if (r.len < MIN_LENGTH) return;
    for (int i = 0; i < 6; i++) begin
      now_on = (r.mods & EDGE_MASK[i]) != 0;
      was_on = (held_mods & EDGE_MASK[i]) != 0;
      if (now_on != was_on) expected_events.push_back('{KIND_KEY, EDGE_SCAN[i], now_on, 1'b0});
    end
    held_mods = r.mods;
    // releases of keys no longer reported
    for (int i = 0; i < KEY_SLOTS; i++) begin
      k = held_keys[i];
      found = 1'b0;
      for (int j = 0; j < KEY_SLOTS; j++) if (r.slots[j] == k) found = 1'b1;
      scan = usage_scan(k);
      if (k > ROLLOVER && !found && scan != NO_SCAN)
        expected_events.push_back('{KIND_KEY, scan[6:0], 1'b0, 1'b0});
    end
    // presses of newly reported keys
    for (int j = 0; j < KEY_SLOTS; j++) begin
      k = r.slots[j];
      found = 1'b0;
      for (int i = 0; i < KEY_SLOTS; i++) if (held_keys[i] == k) found = 1'b1;
      scan = usage_scan(k);
      if (k > ROLLOVER && !found) begin
        if (k == PAUSE_KEY) expected_events.push_back('{KIND_MENU, 7'h00, 1'b1, 1'b0});
        else if (scan != NO_SCAN) expected_events.push_back('{KIND_KEY, scan[6:0], 1'b1, 1'b0});
      end
    end
    held_keys = r.slots;
    if (expected_events.size() > first) expected_events[expected_events.size() - 1].last = 1'b1;
    events_predicted += expected_events.size() - first;
  endtask

  task automatic add_report(input logic [6:0] len, input logic [7:0] mods,
                            input logic [7:0] s0, input logic [7:0] s1, input logic [7:0] s2,
                            input logic [7:0] s3, input logic [7:0] s4, input logic [7:0] s5,
                            input logic wait_idle);
    report_t r;
    r.len       = len;
    r.mods      = mods;
    r.slots[0]  = s0;
    r.slots[1]  = s1;
    r.slots[2]  = s2;
    r.slots[3]  = s3;
    r.slots[4]  = s4;
    r.slots[5]  = s5;
    r.wait_idle = wait_idle;
    pending_reports.push_back(r);
  endtask

  function automatic logic [7:0] pick_usage();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return PAUSE_KEY;
      2: return 8'($urandom_range(0, 255));
      3: return 8'($urandom_range(8'h87, 8'h8b));
      default: return 8'($urandom_range(8'h04, 8'h63));
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    logic offer;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      offer = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        predict_report(offered);
        reports_taken <= reports_taken + 1;
        offer = 1'b0;
        if (!calm && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 18);
      end
      if (!offer) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_reports.size() > 0 &&
                     !(pending_reports[0].wait_idle && events_seen != events_predicted)) begin
          offered = pending_reports.pop_front();
          s_axis_tdata <= IN_BYTES_W'({offered.slots, offered.mods, offered.len});
          offer = 1'b1;
        end
      end
      s_axis_tvalid <= offer;
      calm <= pending_reports.size() < CALM_TAIL;
    end
  end

  // long receiver hold-off so the block backs up into its input
  always @(posedge clk) begin
    if (rst) begin
      hold_left = 0;
      holding <= 1'b0;
    end else begin
      if (!hold_done && reports_taken == 40) begin
        hold_left = 400;
        hold_done = 1'b1;
      end else if (hold_left > 0) begin
        hold_left--;
      end
      holding <= hold_left > 0;
    end
  end

  // monitor
  always @(posedge clk) begin
    key_event_t got;
    key_event_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{m_axis_tuser, m_axis_tdata[6:0], m_axis_tdata[7], m_axis_tlast};
        if (expected_events.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected event: kind %0d code %02h pressed %0d last %0d",
                     got.kind, got.code, got.pressed, got.last);
          mismatches++;
        end else begin
          want = expected_events.pop_front();
          if (got.kind !== want.kind || got.code !== want.code ||
              got.pressed !== want.pressed || got.last !== want.last) begin
            if (mismatches < 10)
              $display(
                "mismatch kind/code/pressed/last: expected %0d %02h %0d %0d got %0d %02h %0d %0d",
                want.kind, want.code, want.pressed, want.last,
                got.kind, got.code, got.pressed, got.last);
            mismatches++;
          end
        end
        events_seen <= events_seen + 1;
      end
      if (recv_gap > 0) recv_gap--;
      else if (!calm && $urandom_range(0, 5) == 0) recv_gap = $urandom_range(1, 18);
      m_axis_tready <= !holding && recv_gap == 0;
    end
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    int         counted;
    report_t    r;
    held_mods = '0;
    held_keys = '0;
    gen_mods  = '0;
    gen_keys  = '0;

    // directed reports
    add_report(7'd8,   8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
    add_report(7'd8,   8'hff, 8'h04, 8'h48, 8'h01, 8'h00, 8'h04, 8'h29, 1'b0);
    add_report(7'd7,   8'h00, 8'h05, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 1'b0);
    add_report(7'd0,   8'hff, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    add_report(7'd8,   8'h00, 8'h05, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    add_report(7'd64,  8'h88, 8'h35, 8'h53, 8'hff, 8'h80, 8'he0, 8'h00, 1'b0);
    add_report(7'd127, 8'h00, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 1'b0);
    add_report(7'd8,   8'h77, 8'h1e, 8'h1f, 8'h20, 8'h21, 8'h22, 8'h23, 1'b0);
    add_report(7'd8,   8'h00, 8'h1d, 8'h26, 8'h27, 8'h3a, 8'h43, 8'h63, 1'b0);
    add_report(7'd8,   8'h77, 8'h8b, 8'h8c, 8'h64, 8'h39, 8'h58, 8'h28, 1'b0);
    add_report(7'd8,   8'h00, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 1'b0);
    add_report(7'd8,   8'h00, 8'h48, 8'h48, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    add_report(7'd8,   8'h00, 8'h00, 8'h00, 8'h48, 8'h00, 8'h00, 8'h00, 1'b0);
    add_report(7'd9,   8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    add_report(7'd8,   8'h02, 8'hfe, 8'h81, 8'h7f, 8'h40, 8'h46, 8'h47, 1'b0);
    add_report(7'd8,   8'h20, 8'h87, 8'h88, 8'h89, 8'h8a, 8'h2c, 8'h3b, 1'b0);
    add_report(7'd8,   8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1);

    // random reports, mostly sequences that keep some keys held
    counted = 0;
    while (counted < RANDOM_REPORTS) begin
      r.wait_idle = (counted % 50 == 49);
      if ($urandom_range(0, 19) == 0) begin
        r.len   = 7'($urandom_range(0, 7));
        r.mods  = 8'($urandom_range(0, 255));
        for (int j = 0; j < KEY_SLOTS; j++) r.slots[j] = 8'($urandom_range(0, 255));
      end else begin
        r.len = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(8, 127)) : MIN_LENGTH;
        if ($urandom_range(0, 2) == 0) gen_mods = 8'($urandom_range(0, 255));
        else gen_mods = gen_mods ^ (8'h01 << $urandom_range(0, 7));
        if ($urandom_range(0, 19) == 0) begin
          for (int j = 0; j < KEY_SLOTS; j++) gen_keys[j] = ROLLOVER;
        end else begin
          for (int j = 0; j < KEY_SLOTS; j++)
            gen_keys[j] = $urandom_range(0, 1) ? gen_keys[$urandom_range(0, KEY_SLOTS - 1)]
                                               : pick_usage();
        end
        r.mods  = gen_mods;
        r.slots = gen_keys;
        counted++;
      end
      pending_reports.push_back(r);
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk); while (pending_reports.size() > 0 || s_axis_tvalid);
    do @(posedge clk); while (events_seen < events_predicted);
    repeat (40) @(posedge clk);

    if (expected_events.size() != 0) begin
      $display("%0d expected events never arrived", expected_events.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
